>>> rtl/core/lir_pkg.sv
// Shared types and constants for the linear interpolation resampler.
// No dependencies; compiled first.
package lir_pkg;

  localparam int SAMPLE_BITS_DEF  = 24;
  localparam int FRAC_BITS_DEF    = 16;
  localparam int MAX_UPSAMPLE_DEF = 16;

  // Fixed by the register map and the per-item result bound
  localparam int STEP_W       = 23;
  localparam int CFG_W        = 23;
  localparam int CFG_IDX_W    = 1;
  localparam int RESULT_LIMIT = 32;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [STEP_W-1:0] STEP_RESET = 23'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_RATIO   = 1'b0,
    REG_PASS_THROUGH = 1'b1
  } reg_idx_t;

  typedef enum logic {
    OP_RESAMPLE = 1'b0,
    OP_PASS     = 1'b1
  } op_t;

  typedef struct packed {
    op_t  op;
    logic is_final;
  } cmd_t;

endpackage

>>> rtl/core/lir_if.sv
// Valid/ready stream interfaces for source samples and resampled results.
// Depends on lir_pkg.
interface lir_in_if import lir_pkg::*; #(parameter int SAMPLE_BITS = SAMPLE_BITS_DEF) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample_in;
  logic                   is_final;

  modport source (output valid, output sample_in, output is_final, input ready);
  modport sink   (input valid, input sample_in, input is_final, output ready);
endinterface

interface lir_out_if import lir_pkg::*; #(parameter int SAMPLE_BITS = SAMPLE_BITS_DEF) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample_out;
  logic                   run_last;
  logic                   stream_end;

  modport source (output valid, output sample_out, output run_last, output stream_end,
                  input ready);
  modport sink   (input valid, input sample_out, input run_last, input stream_end,
                  output ready);
endinterface

>>> rtl/core/lir_front.sv
// Front end: registers incoming source samples and tags each with its operation.
// Depends on lir_pkg and lir_in_if.
module lir_front import lir_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  lir_in_if.sink                 src,
  input  logic                   pass_through,
  output logic                   q_valid,
  input  logic                   q_ready,
  output cmd_t                   q_ctrl,
  output logic [SAMPLE_BITS-1:0] q_sample
);

  logic                   hold_valid;
  cmd_t                   hold_ctrl;
  logic [SAMPLE_BITS-1:0] hold_sample;
  logic                   take;

  assign src.ready = !hold_valid || q_ready;
  assign take      = src.valid && src.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (take) begin
      hold_valid <= 1'b1;
    end else if (q_ready) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold_ctrl.op       <= pass_through ? OP_PASS : OP_RESAMPLE;
      hold_ctrl.is_final <= src.is_final;
      hold_sample        <= src.sample_in;
    end
  end

  assign q_valid  = hold_valid;
  assign q_ctrl   = hold_ctrl;
  assign q_sample = hold_sample;

endmodule

>>> rtl/core/lir_queue.sv
// Short FIFO that decouples the front end from the interpolation engine.
// Depends on lir_pkg.
module lir_queue import lir_pkg::*; #(
  parameter int DATA_W = 26
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  logic [DATA_W-1:0] push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output logic [DATA_W-1:0] pop_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_W-1:0] slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  fill;
  logic              do_push;
  logic              do_pop;

  assign push_ready = fill != CNT_W'(QUEUE_DEPTH);
  assign pop_valid  = fill != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

>>> rtl/core/lir_back.sv
// Interpolation engine: walks output positions of one source interval, one result
// a cycle unless stalled, to an output register. Depends on lir_pkg, lir_out_if.
module lir_back import lir_pkg::*; #(
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int MAX_UPSAMPLE = MAX_UPSAMPLE_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  output logic                   q_ready,
  input  cmd_t                   q_ctrl,
  input  logic [SAMPLE_BITS-1:0] q_sample,
  input  logic [STEP_W-1:0]      step_ratio,
  lir_out_if.source              dst
);

  localparam int SW       = SAMPLE_BITS;
  localparam int FB       = FRAC_BITS;
  localparam int POS_W    = ((STEP_W > FB) ? STEP_W : FB) + 2;
  localparam int CNT_W    = $clog2(MAX_UPSAMPLE + 1);
  localparam int N_W      = $clog2(RESULT_LIMIT + 1);
  localparam int PROD_W   = SW + FB + 2;
  localparam int MIN_STEP = ((1 << FB) + MAX_UPSAMPLE - 1) / MAX_UPSAMPLE;

  localparam logic [POS_W-1:0] ONE_P =
    {{(POS_W-FB-1){1'b0}}, 1'b1, {FB{1'b0}}};
  localparam logic [POS_W-1:0]  MIN_P  = POS_W'(MIN_STEP);
  localparam logic [CNT_W-1:0]  MU_C   = CNT_W'(MAX_UPSAMPLE);
  localparam logic [N_W-1:0]    LIM_C  = N_W'(RESULT_LIMIT);
  localparam logic [PROD_W-1:0] HALF_P = {{(SW+2){1'b0}}, 1'b1, {(FB-1){1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_INTERP = 3'b010,
    S_TAIL   = 3'b100
  } state_t;

  state_t           state;
  logic [SW-1:0]    prior;
  logic             have_prior;
  logic [SW-1:0]    cur;
  logic             fin;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] eff_step;
  logic [CNT_W-1:0] cnt;
  logic [N_W-1:0]   num;

  logic             out_valid;
  logic [SW-1:0]    out_sample;
  logic             out_last;
  logic             out_end;

  logic             out_free;
  logic             pop;
  logic             can_emit;
  logic             more;
  logic             tail_emits;
  logic [POS_W-1:0] pos_step;
  logic [POS_W-1:0] pos_adj_step;
  logic [POS_W-1:0] pos_adj_now;
  logic [CNT_W-1:0] cnt_inc;
  logic [N_W-1:0]   num_inc;

  logic signed [SW:0]       diff;
  logic signed [FB:0]       frac_s;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_rnd;
  logic signed [PROD_W-1:0] prod_sh;
  logic [SW-1:0]            interp_val;

  logic          emit;
  logic [SW-1:0] emit_sample;
  logic          emit_last;
  logic          emit_end;

  assign out_free = !out_valid || dst.ready;
  assign q_ready  = (state == S_IDLE) && (q_ctrl.op != OP_PASS || out_free);
  assign pop      = q_valid && q_ready;

  // Loop bookkeeping for the current position
  always_comb begin
    can_emit     = (pos < ONE_P) && (cnt < MU_C) && (num < LIM_C);
    pos_step     = pos + eff_step;
    cnt_inc      = cnt + 1'b1;
    num_inc      = num + 1'b1;
    more         = (pos_step < ONE_P) && (cnt_inc < MU_C) && (num_inc < LIM_C);
    pos_adj_step = (pos_step >= ONE_P) ? pos_step - ONE_P : '0;
    pos_adj_now  = (pos >= ONE_P) ? pos - ONE_P : '0;
    tail_emits   = (pos_adj_step < ONE_P) && (num_inc < LIM_C);
  end

  // prior + round(frac * (cur - prior)); stays between the two samples
  always_comb begin
    diff       = $signed({cur[SW-1], cur}) - $signed({prior[SW-1], prior});
    frac_s     = $signed({1'b0, pos[FB-1:0]});
    prod       = diff * frac_s;
    prod_rnd   = prod + $signed(HALF_P);
    prod_sh    = prod_rnd >>> FB;
    interp_val = prior + prod_sh[SW-1:0];
  end

  always_comb begin
    emit        = 1'b0;
    emit_sample = prior;
    emit_last   = 1'b0;
    emit_end    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (pop && q_ctrl.op == OP_PASS) begin
          emit        = 1'b1;
          emit_sample = q_sample;
          emit_last   = 1'b1;
          emit_end    = q_ctrl.is_final;
        end
      end
      S_INTERP: begin
        if (can_emit && out_free) begin
          emit        = 1'b1;
          emit_sample = interp_val;
          emit_last   = !more && !(fin && tail_emits);
          emit_end    = fin && !more && !tail_emits;
        end
      end
      S_TAIL: begin
        if (can_emit && out_free) begin
          emit        = 1'b1;
          emit_sample = prior;
          emit_last   = !more;
          emit_end    = !more;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      prior      <= '0;
      have_prior <= 1'b0;
      pos        <= '0;
      cnt        <= '0;
      num        <= '0;
      out_valid  <= 1'b0;
      eff_step   <= '0;
    end else begin
      eff_step  <= (POS_W'(step_ratio) < MIN_P) ? MIN_P : POS_W'(step_ratio);
      out_valid <= emit || (out_valid && !dst.ready);
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            cnt <= '0;
            num <= '0;
            if (q_ctrl.op == OP_PASS) begin
              if (q_ctrl.is_final) begin
                prior      <= '0;
                have_prior <= 1'b0;
                pos        <= '0;
              end
            end else if (!have_prior) begin
              prior      <= q_sample;
              have_prior <= 1'b1;
              if (q_ctrl.is_final) begin
                state <= S_TAIL;
              end
            end else begin
              state <= S_INTERP;
            end
          end
        end
        S_INTERP: begin
          if (can_emit) begin
            if (out_free) begin
              pos <= pos_step;
              cnt <= cnt_inc;
              num <= num_inc;
            end
          end else begin
            // interval done: move to the next source sample
            pos   <= pos_adj_now;
            prior <= cur;
            cnt   <= '0;
            state <= fin ? S_TAIL : S_IDLE;
          end
        end
        S_TAIL: begin
          if (can_emit) begin
            if (out_free) begin
              pos <= pos_step;
              cnt <= cnt_inc;
              num <= num_inc;
            end
          end else begin
            prior      <= '0;
            have_prior <= 1'b0;
            pos        <= '0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_sample;
      fin <= q_ctrl.is_final;
    end
    if (emit) begin
      out_sample <= emit_sample;
      out_last   <= emit_last;
      out_end    <= emit_end;
    end
  end

  assign dst.valid      = out_valid;
  assign dst.sample_out = out_sample;
  assign dst.run_last   = out_last;
  assign dst.stream_end = out_end;

endmodule

>>> rtl/core/linear_interp_resampler_top.sv
// Linear interpolation sample rate converter.
//
// Channels: src takes source samples (sample_in, is_final); dst gives results
// (sample_out, run_last, stream_end). Both are valid/ready; a beat moves when
// both are high. Configuration: cfg_we/cfg_index/cfg_data, index 0 is the Q7.16
// step (source samples per output), index 1 the pass-through flag. Write only
// while the block is idle.
// Path: a sample passes the input register and the queue to the engine, which
// registers it, then registers each result in the output register. The engine
// pops an item only while idle and emits one result per cycle unless the output
// is stalled, closing each source interval in a step of its own; a final item
// also emits its tail. A pass-through item is emitted as it is popped. With a
// single interpolation multiplier, it takes a new item only when idle again.
// Reset: synchronous; clears the stream state (no prior sample, position zero),
// step to 1.0, pass-through off. No clearing pass is needed.
// Stall: a held result stays in the output register; the two-entry queue and
// input register keep taking samples until they fill, then src.ready drops.
module linear_interp_resampler_top import lir_pkg::*; #(
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int MAX_UPSAMPLE = MAX_UPSAMPLE_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  lir_in_if.sink               src,
  lir_out_if.source            dst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int Q_W = $bits(cmd_t) + SAMPLE_BITS;

  logic [STEP_W-1:0]      step_ratio;
  logic                   pass_through;

  logic                   f_valid;
  logic                   f_ready;
  cmd_t                   f_ctrl;
  logic [SAMPLE_BITS-1:0] f_sample;

  logic                   b_valid;
  logic                   b_ready;
  logic [Q_W-1:0]         b_data;
  cmd_t                   b_ctrl;
  logic [SAMPLE_BITS-1:0] b_sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_ratio   <= STEP_RESET;
      pass_through <= 1'b0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_STEP_RATIO:   step_ratio   <= cfg_data[STEP_W-1:0];
        REG_PASS_THROUGH: pass_through <= cfg_data[0];
        default: begin
          pass_through <= pass_through;
        end
      endcase
    end
  end

  lir_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .src          (src),
    .pass_through (pass_through),
    .q_valid      (f_valid),
    .q_ready      (f_ready),
    .q_ctrl       (f_ctrl),
    .q_sample     (f_sample)
  );

  lir_queue #(
    .DATA_W(Q_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  ({f_ctrl, f_sample}),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_data)
  );

  assign b_ctrl   = b_data[Q_W-1:SAMPLE_BITS];
  assign b_sample = b_data[SAMPLE_BITS-1:0];

  lir_back #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .FRAC_BITS    (FRAC_BITS),
    .MAX_UPSAMPLE (MAX_UPSAMPLE)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (b_valid),
    .q_ready    (b_ready),
    .q_ctrl     (b_ctrl),
    .q_sample   (b_sample),
    .step_ratio (step_ratio),
    .dst        (dst)
  );

endmodule

>>> rtl/core/lir_checker.sv
// Port-level checks on the resampler's result channel, bound to the top level.
// Depends on linear_interp_resampler_top.
module lir_checker import lir_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   dst_valid,
  input logic                   dst_ready,
  input logic [SAMPLE_BITS-1:0] dst_sample,
  input logic                   dst_run_last,
  input logic                   dst_stream_end
);

  // Out of reset no result may be pending
  a_reset_empty: assert property (@(posedge clk) (!rst && $past(rst)) |-> !dst_valid)
    else $error("result valid right after reset");

  // The stream end is always the last result of its item
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (dst_valid && dst_stream_end) |-> dst_run_last)
    else $error("stream_end without run_last");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    (dst_valid && !dst_ready) |=> dst_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    (dst_valid && !dst_ready) |=>
      ($stable(dst_sample) && $stable(dst_run_last) && $stable(dst_stream_end)))
    else $error("result changed while stalled");

endmodule

bind linear_interp_resampler_top lir_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_chk (
  .clk            (clk),
  .rst            (rst),
  .dst_valid      (dst.valid),
  .dst_ready      (dst.ready),
  .dst_sample     (dst.sample_out),
  .dst_run_last   (dst.run_last),
  .dst_stream_end (dst.stream_end)
);

>>> sim/lir_output_checker.sv
// Result checker for the linear interpolation resampler: watches both stream channels
// and the register port, predicts every result and compares it field by field.
// Depends on lir_pkg.
module lir_output_checker import lir_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [SAMPLE_BITS_DEF-1:0] in_sample,
  input  logic                       in_final,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [SAMPLE_BITS_DEF-1:0] out_sample,
  input  logic                       out_run_last,
  input  logic                       out_stream_end,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data,
  output int                         mismatches,
  output int                         outstanding,
  output int                         compared
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [SAMPLE_BITS_DEF-1:0] sample_t;

  typedef struct packed {
    sample_t value;
    logic    run_last;
    logic    stream_end;
  } result_t;

  localparam int ONE_POS   = 1 << FRAC_BITS_DEF;
  localparam int MIN_STEP  = (ONE_POS + MAX_UPSAMPLE_DEF - 1) / MAX_UPSAMPLE_DEF;
  localparam int PRINT_CAP = 40;

  logic [STEP_W-1:0] step_reg;
  logic              pass_reg;
  sample_t           held_sample;
  logic              held_valid;
  logic [31:0]       position;
  result_t           expected_q[$];
  int                fail_count;
  int                n_compared;

  function automatic sample_t lerp(input sample_t a, input sample_t b, input logic [31:0] frac);
    longint prod;
    prod = (longint'(b) - longint'(a)) * longint'(frac);
    // round half up, then floor
    return sample_t'(longint'(a) + ((prod + longint'(ONE_POS / 2)) >>> FRAC_BITS_DEF));
  endfunction

  function automatic void restart_stream();
    held_sample = '0;
    held_valid  = 1'b0;
    position    = '0;
  endfunction

  task automatic report_mismatch(input string field, input logic signed [31:0] got,
                                 input logic signed [31:0] want);
    if (fail_count < PRINT_CAP)
      $display("%0t: %s mismatch on result %0d: got %0d, expected %0d",
               $time, field, n_compared, got, want);
    fail_count++;
  endtask

  task automatic predict_beat(input sample_t s, input logic fin);
    sample_t     vals[$];
    logic [31:0] stp;
    int          c;
    stp = (step_reg < MIN_STEP) ? 32'(MIN_STEP) : 32'(step_reg);
    if (pass_reg) begin
      vals.push_back(s);
      if (fin) restart_stream();
    end else begin
      if (!held_valid) begin
        held_sample = s;
        held_valid  = 1'b1;
      end else begin
        c = 0;
        while (position < ONE_POS && c < MAX_UPSAMPLE_DEF && vals.size() < RESULT_LIMIT) begin
          vals.push_back(lerp(held_sample, s, position));
          position += stp;
          c++;
        end
        position = (position >= ONE_POS) ? position - ONE_POS : '0;
        held_sample = s;
      end
      // tail of the stream: positions past the last sample repeat it
      if (fin) begin
        c = 0;
        while (position < ONE_POS && c < MAX_UPSAMPLE_DEF && vals.size() < RESULT_LIMIT) begin
          vals.push_back(held_sample);
          position += stp;
          c++;
        end
        restart_stream();
      end
    end
    foreach (vals[i])
      expected_q.push_back('{vals[i], i == vals.size() - 1, fin && i == vals.size() - 1});
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      step_reg = STEP_RESET;
      pass_reg = 1'b0;
      restart_stream();
      expected_q.delete();
      fail_count = 0;
      n_compared = 0;
    end else begin
      if (in_valid && in_ready)
        predict_beat(sample_t'(in_sample), in_final);
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected beat", out_sample, 0);
        end else begin
          want = expected_q.pop_front();
          if (out_sample !== want.value)
            report_mismatch("sample_out", sample_t'(out_sample), want.value);
          if (out_run_last !== want.run_last)
            report_mismatch("run_last", out_run_last, want.run_last);
          if (out_stream_end !== want.stream_end)
            report_mismatch("stream_end", out_stream_end, want.stream_end);
          n_compared++;
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_STEP_RATIO)
          step_reg = cfg_data[STEP_W-1:0];
        else if (cfg_index == REG_PASS_THROUGH)
          pass_reg = cfg_data[0];
      end
    end
    mismatches  <= fail_count;
    outstanding <= expected_q.size();
    compared    <= n_compared;
  end

endmodule

>>> sim/linear_interp_resampler_top_test.sv
// Stimulus and verdict for the linear interpolation resampler: directed streams, a long
// output stall, then random streams over many register settings and idle patterns.
// Depends on lir_pkg, lir_if, the resampler RTL and lir_output_checker.
module linear_interp_resampler_top_test import lir_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [SAMPLE_BITS_DEF-1:0] sample_t;

  localparam sample_t SAMPLE_MAX    = sample_t'(24'h7FFFFF);
  localparam sample_t SAMPLE_MIN    = sample_t'(24'h800000);
  localparam int      SETTLE_CYCLES = 40;
  localparam int      DRAIN_LIMIT   = 20000;
  localparam int      LONG_HOLD     = 400;
  localparam int      ITEMS_PER_SET = 24;
  localparam int      RUN_LIMIT_NS  = 2_000_000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  reg_idx_t          cfg_index = REG_STEP_RATIO;
  logic [CFG_W-1:0]  cfg_data = '0;

  int src_gap = 0;
  int sink_gap_pct = 0;
  int hold_req = 0;
  int beats_sent = 0;
  int settings_used = 0;
  int mismatches;
  int outstanding;
  int compared;

  lir_in_if  src_ch ();
  lir_out_if dst_ch ();

  linear_interp_resampler_top uut (
    .clk       (clk),
    .rst       (rst),
    .src       (src_ch),
    .dst       (dst_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lir_output_checker out_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (src_ch.valid),
    .in_ready       (src_ch.ready),
    .in_sample      (src_ch.sample_in),
    .in_final       (src_ch.is_final),
    .out_valid      (dst_ch.valid),
    .out_ready      (dst_ch.ready),
    .out_sample     (dst_ch.sample_out),
    .out_run_last   (dst_ch.run_last),
    .out_stream_end (dst_ch.stream_end),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .compared       (compared)
  );

  // 4 ns period
  always #2 clk = ~clk;

  // Output side: random back-pressure, plus a long hold each time one is requested.
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    dst_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        dst_ch.ready <= 1'b0;
      end else begin
        dst_ch.ready <= ($urandom_range(99) >= sink_gap_pct);
      end
    end
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Run limit reached with %0d results outstanding", outstanding);
    $display("Regression FAIL");
    $finish;
  end

  // Leave valid high after the beat; the next call either holds it or drops it.
  task automatic send_beat(input sample_t s, input logic fin);
    while ($urandom_range(99) < src_gap) begin
      src_ch.valid <= 1'b0;
      @(posedge clk);
    end
    src_ch.valid     <= 1'b1;
    src_ch.sample_in <= s;
    src_ch.is_final  <= fin;
    @(posedge clk);
    while (!src_ch.ready) @(posedge clk);
    beats_sent++;
  endtask

  // Wait for every expected result, then for beats that emit nothing to clear the engine.
  task automatic drain();
    int waited;
    waited = 0;
    src_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [STEP_W-1:0] step, input logic pass);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_STEP_RATIO;
    cfg_data  <= CFG_W'(step);
    @(posedge clk);
    // upper bits of the flag write are don't-care; toggle them anyway
    cfg_index <= REG_PASS_THROUGH;
    cfg_data  <= {(CFG_W - 1)'($urandom), pass};
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic sample_t pick_sample(input sample_t prev);
    case ($urandom_range(7))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2, 3: return sample_t'($urandom);
      default: return prev + sample_t'(int'($urandom_range(0, 4096)) - 2048);
    endcase
  endfunction

  initial begin
    sample_t           prev;
    logic [STEP_W-1:0] step;
    int                sent;
    int                run_len;
    bit                closed;
    prev = '0;
    src_ch.valid     <= 1'b0;
    src_ch.sample_in <= '0;
    src_ch.is_final  <= 1'b0;
    src_gap = 11;
    sink_gap_pct <= 60;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // lone final sample: its own unit interval repeats it
    configure(STEP_RESET, 1'b0);
    send_beat(SAMPLE_MAX, 1'b1);

    // full-scale swings at a step below the clamp: 16 per interval, 32 on the final beat
    configure('0, 1'b0);
    send_beat(SAMPLE_MAX, 1'b0);
    send_beat(SAMPLE_MIN, 1'b0);
    send_beat(SAMPLE_MAX, 1'b1);

    // half step: ties at one half round toward +inf
    configure(23'd32768, 1'b0);
    send_beat(0, 1'b0);
    send_beat(1, 1'b0);
    send_beat(0, 1'b0);
    send_beat(-1, 1'b0);
    send_beat(3, 1'b1);

    // step beyond the stream length: one result, later intervals and final beat empty
    configure('1, 1'b0);
    send_beat(100, 1'b0);
    send_beat(-100, 1'b0);
    send_beat(5, 1'b0);
    send_beat(7, 1'b1);

    // flip to pass-through mid-stream and back; the stream state carries over
    configure(23'd49152, 1'b0);
    send_beat(1000, 1'b0);
    send_beat(-5000, 1'b0);
    configure(23'd49152, 1'b1);
    send_beat(SAMPLE_MIN, 1'b0);
    configure(23'd49152, 1'b0);
    send_beat(7777, 1'b0);
    send_beat(-1, 1'b1);
    configure(STEP_RESET, 1'b1);
    send_beat(42, 1'b1);

    // hold the output long enough for the input side to back up
    configure(23'd4096, 1'b0);
    src_gap = 0;
    hold_req <= hold_req + 1;
    for (int i = 0; i < 24; i++) begin
      prev = pick_sample(prev);
      send_beat(prev, i == 23);
    end

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          src_gap = 11;
          sink_gap_pct <= 60;
        end
        1: begin
          src_gap = 60;
          sink_gap_pct <= 11;
        end
        default: begin
          src_gap = 0;
          sink_gap_pct <= 0;
        end
      endcase
      for (int k = 0; k < 5; k++) begin
        case ((ph * 5 + k) % 6)
          0: step = 23'd4096;
          1: step = '0;
          2: step = 23'd4194304;
          3: step = '1;
          4: step = STEP_W'($urandom_range(4096, 98304));
          default: step = STEP_W'($urandom);
        endcase
        configure(step, (ph * 5 + k) % 5 == 4);
        sent = 0;
        while (sent < ITEMS_PER_SET) begin
          run_len = $urandom_range(1, 12);
          closed = ($urandom_range(7) != 0);
          for (int i = 0; i < run_len; i++) begin
            prev = pick_sample(prev);
            // mostly well-formed streams, with an odd stray final flag
            send_beat(prev, (closed && i == run_len - 1) || $urandom_range(24) == 0);
            sent++;
          end
        end
      end
    end

    drain();
    $display("Sent %0d source beats over %0d register settings; %0d results compared.",
             beats_sent, settings_used, compared);
    $display("Covered clamped, unity, fractional, huge and pass-through steps, and a long stall.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d expected results never arrived", mismatches, outstanding);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
